### design/fvp_pkg.sv
// Shared types, constants and CORDIC angle table for the flow vector to polar block.
package fvp_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned PreShift = 16;
  localparam int unsigned AngleBits = 33;
  localparam logic [32:0] QuarterTurn = 33'd1073741824;

  typedef struct packed {
    logic signed [15:0] x_component;
    logic signed [15:0] y_component;
  } fvp_in_t;

  typedef struct packed {
    logic [7:0] angle_code;
    logic [7:0] magnitude;
  } fvp_out_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] k);
    case (k)
      5'd0:  atan_turns = 32'd536870912;
      5'd1:  atan_turns = 32'd316933406;
      5'd2:  atan_turns = 32'd167458907;
      5'd3:  atan_turns = 32'd85004756;
      5'd4:  atan_turns = 32'd42667331;
      5'd5:  atan_turns = 32'd21354465;
      5'd6:  atan_turns = 32'd10679838;
      5'd7:  atan_turns = 32'd5340245;
      5'd8:  atan_turns = 32'd2670163;
      5'd9:  atan_turns = 32'd1335087;
      5'd10: atan_turns = 32'd667544;
      5'd11: atan_turns = 32'd333772;
      5'd12: atan_turns = 32'd166886;
      5'd13: atan_turns = 32'd83443;
      5'd14: atan_turns = 32'd41722;
      5'd15: atan_turns = 32'd20861;
      5'd16: atan_turns = 32'd10430;
      5'd17: atan_turns = 32'd5215;
      5'd18: atan_turns = 32'd2608;
      5'd19: atan_turns = 32'd1304;
      5'd20: atan_turns = 32'd652;
      5'd21: atan_turns = 32'd326;
      5'd22: atan_turns = 32'd163;
      5'd23: atan_turns = 32'd81;
      default: atan_turns = 32'd0;
    endcase
  endfunction

endpackage

### design/flow_vector_to_polar_core.sv
// Top level of the flow vector to polar converter.
// Converts one flow vector (x, y) per word into a direction code and a length.
// Input channel in_valid_i/in_ready_o carries x_component and y_component;
// output channel out_valid_o/out_ready_i carries angle_code and magnitude.
// angle_code is floor(255*theta/turn) with theta measured from +y toward +x;
// a zero vector gives 0. magnitude is floor(sqrt(x^2+y^2)) >> FRAC_BITS in whole units, capped at 255.
// Throughput: one word per cycle, sustained while the receiver takes words.
// Pipeline: 1 front register, 24 back stages (the longer of the 24 CORDIC
// steps and the COMPONENT_BITS+1 root steps) and 1 output register. The
// CORDIC steps set the depth.
// Reset clears all valid flags; no item is in flight after reset.
// When the receiver stalls, the output word holds, the back pipeline freezes,
// the front register fills and then in_ready_o drops.
module flow_vector_to_polar_core import fvp_pkg::*; #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  fvp_in_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output fvp_out_t out_data_o
);

  localparam int OpBits = COMPONENT_BITS + PreShift + 18;

  logic                             fr_valid, fr_ready, fr_zero;
  logic signed [OpBits-1:0]         fr_re, fr_im;
  logic [1:0]                       fr_quad;
  logic [2*COMPONENT_BITS:0]        fr_sq;

  fvp_front #(.CompBits(COMPONENT_BITS), .OpBits(OpBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .x_i(COMPONENT_BITS'(in_data_i.x_component)),
    .y_i(COMPONENT_BITS'(in_data_i.y_component)),
    .fr_valid_o(fr_valid), .fr_ready_i(fr_ready),
    .fr_re_o(fr_re), .fr_im_o(fr_im), .fr_quad_o(fr_quad),
    .fr_zero_o(fr_zero), .fr_sq_o(fr_sq)
  );

  fvp_back #(.CompBits(COMPONENT_BITS), .FracBits(FRAC_BITS), .OpBits(OpBits)) u_back (
    .clk_i, .rst_ni,
    .fr_valid_i(fr_valid), .fr_ready_o(fr_ready),
    .fr_re_i(fr_re), .fr_im_i(fr_im), .fr_quad_i(fr_quad),
    .fr_zero_i(fr_zero), .fr_sq_i(fr_sq),
    .out_valid_o, .out_ready_i,
    .angle_o(out_data_o.angle_code), .mag_o(out_data_o.magnitude)
  );

endmodule

### design/fvp_front.sv
// Front end: accepts vectors, squares the components and reduces to the first quadrant.
module fvp_front import fvp_pkg::*; #(
  parameter int CompBits = 16,
  parameter int OpBits = 50
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [CompBits-1:0]  x_i,
  input  logic signed [CompBits-1:0]  y_i,
  output logic                        fr_valid_o,
  input  logic                        fr_ready_i,
  output logic signed [OpBits-1:0]    fr_re_o,
  output logic signed [OpBits-1:0]    fr_im_o,
  output logic [1:0]                  fr_quad_o,
  output logic                        fr_zero_o,
  output logic [2*CompBits:0]         fr_sq_o
);

  logic signed [OpBits-1:0] re0, im0, re1, im1;
  logic [1:0] quad;
  logic [CompBits:0] ax, ay;
  logic [2*CompBits+1:0] sq_full;

  logic                     valid_q;
  logic signed [OpBits-1:0] re_q, im_q;
  logic [1:0]               quad_q;
  logic                     zero_q;
  logic [2*CompBits:0]      sq_q;

  assign in_ready_o = !valid_q || fr_ready_i;

  always_comb begin
    re0 = OpBits'(y_i) <<< PreShift;
    im0 = OpBits'(x_i) <<< PreShift;
    if (re0 > 0 && im0 >= 0) begin
      quad = 2'd0; re1 = re0; im1 = im0;
    end else if (im0 > 0 && re0 <= 0) begin
      quad = 2'd1; re1 = im0; im1 = -re0;
    end else if (re0 < 0 && im0 <= 0) begin
      quad = 2'd2; re1 = -re0; im1 = -im0;
    end else begin
      quad = 2'd3; re1 = -im0; im1 = re0;
    end
    ax = x_i[CompBits-1] ? (CompBits+1)'(-$signed({x_i[CompBits-1], x_i}))
                         : (CompBits+1)'(x_i);
    ay = y_i[CompBits-1] ? (CompBits+1)'(-$signed({y_i[CompBits-1], y_i}))
                         : (CompBits+1)'(y_i);
    sq_full = (2*CompBits+2)'(ax) * (2*CompBits+2)'(ax)
            + (2*CompBits+2)'(ay) * (2*CompBits+2)'(ay);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      re_q   <= re1;
      im_q   <= im1;
      quad_q <= quad;
      zero_q <= (x_i == '0) && (y_i == '0);
      sq_q   <= sq_full[2*CompBits:0];
    end
  end

  assign fr_valid_o = valid_q;
  assign fr_re_o    = re_q;
  assign fr_im_o    = im_q;
  assign fr_quad_o  = quad_q;
  assign fr_zero_o  = zero_q;
  assign fr_sq_o    = sq_q;

endmodule

### design/fvp_back.sv
// Back end: pipelined CORDIC angle and pipelined integer square root with output register.
module fvp_back import fvp_pkg::*; #(
  parameter int CompBits = 16,
  parameter int FracBits = 8,
  parameter int OpBits = 50
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fr_valid_i,
  output logic                        fr_ready_o,
  input  logic signed [OpBits-1:0]    fr_re_i,
  input  logic signed [OpBits-1:0]    fr_im_i,
  input  logic [1:0]                  fr_quad_i,
  input  logic                        fr_zero_i,
  input  logic [2*CompBits:0]         fr_sq_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  angle_o,
  output logic [7:0]                  mag_o
);

  localparam int Steps = CordicSteps;
  localparam int SqBits = 2*CompBits+2;
  localparam int RootBits = SqBits/2;
  localparam int RootSteps = RootBits;

  // one pipeline: stage s runs CORDIC step s (for s < Steps) and root step s (for s < RootSteps)
  localparam int Stages = (Steps > RootSteps) ? Steps : RootSteps;

  logic                        v_q   [Stages+1];
  logic signed [OpBits-1:0]    re_q  [Stages+1];
  logic signed [OpBits-1:0]    im_q  [Stages+1];
  logic signed [AngleBits:0]   acc_q [Stages+1];
  logic [1:0]                  qd_q  [Stages+1];
  logic                        z_q   [Stages+1];
  logic [SqBits-1:0]           rem_q [Stages+1];
  logic [RootBits-1:0]         rt_q  [Stages+1];

  logic adv;
  logic                     ov_q;
  logic [7:0]               ang_q, mag_q;

  assign adv = !ov_q || out_ready_i;
  assign fr_ready_o = adv;

  always_comb begin
    v_q[0]   = fr_valid_i;
    re_q[0]  = fr_re_i;
    im_q[0]  = fr_im_i;
    acc_q[0] = '0;
    qd_q[0]  = fr_quad_i;
    z_q[0]   = fr_zero_i;
    rem_q[0] = SqBits'(fr_sq_i);
    rt_q[0]  = '0;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic signed [OpBits-1:0]  re_d, im_d;
    logic signed [AngleBits:0] acc_d;
    logic [SqBits-1:0]         rem_d;
    logic [RootBits-1:0]       rt_d;
    logic [RootBits+1:0]       trial;
    logic [SqBits-1:0]         top;

    always_comb begin
      re_d  = re_q[s];
      im_d  = im_q[s];
      acc_d = acc_q[s];
      if (s < Steps) begin
        if (im_q[s] >= 0) begin
          re_d  = re_q[s] + (im_q[s] >>> s);
          im_d  = im_q[s] - (re_q[s] >>> s);
          acc_d = acc_q[s] + (AngleBits+1)'(atan_turns(5'(s)));
        end else begin
          re_d  = re_q[s] - (im_q[s] >>> s);
          im_d  = im_q[s] + (re_q[s] >>> s);
          acc_d = acc_q[s] - (AngleBits+1)'(atan_turns(5'(s)));
        end
      end
      rem_d = rem_q[s];
      rt_d  = rt_q[s];
      top   = '0;
      trial = '0;
      if (s < RootSteps) begin
        top   = rem_q[s] >> (2*(RootSteps-1-s));
        trial = {rt_q[s], 2'b01};
        if (top >= SqBits'(trial)) begin
          rem_d = rem_q[s] - (SqBits'(trial) << (2*(RootSteps-1-s)));
          rt_d  = {rt_q[s][RootBits-2:0], 1'b1};
        end else begin
          rt_d  = {rt_q[s][RootBits-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (adv) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        re_q[s+1]  <= re_d;
        im_q[s+1]  <= im_d;
        acc_q[s+1] <= acc_d;
        qd_q[s+1]  <= qd_q[s];
        z_q[s+1]   <= z_q[s];
        rem_q[s+1] <= rem_d;
        rt_q[s+1]  <= rt_d;
      end
    end
  end

  logic [AngleBits-1:0] acc_cl, total;
  logic [AngleBits+7:0] prod;
  logic [RootBits-1:0]  root_sh;
  logic [7:0]           ang_d, mag_d;

  always_comb begin
    if (acc_q[Stages] < 0) begin
      acc_cl = '0;
    end else if (acc_q[Stages] > $signed({1'b0, QuarterTurn - 33'd1})) begin
      acc_cl = QuarterTurn - 33'd1;
    end else begin
      acc_cl = acc_q[Stages][AngleBits-1:0];
    end
    total = acc_cl + (QuarterTurn * 33'(qd_q[Stages]));
    prod  = (AngleBits+8)'(total) * (AngleBits+8)'(255);
    ang_d = z_q[Stages] ? 8'd0 : prod[39:32];
    root_sh = rt_q[Stages] >> FracBits;
    mag_d = (root_sh > RootBits'(255)) ? 8'd255 : root_sh[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= v_q[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v_q[Stages]) begin
      ang_q <= ang_d;
      mag_q <= mag_d;
    end
  end

  assign out_valid_o = ov_q;
  assign angle_o = ang_q;
  assign mag_o = mag_q;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(ang_q) && $stable(mag_q))
    else $error("output word changed under stall");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v_q[Stages] && z_q[Stages] |=> ang_q == 8'd0)
    else $error("zero vector gave nonzero angle");
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ov_q |-> fr_ready_o)
    else $error("pipeline stalled with empty output");
`endif

endmodule
